[rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared constants for the sprite screen projection block: number formats,
// register map and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  // Fraction bits of the Q format used by coordinates.
  localparam int unsigned CoordFracBits = 16;
  // Width of the clipped column and row outputs.
  localparam int unsigned ScreenBits    = 12;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned DimW     = 13;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] RegViewerX = 3'd0;
  localparam logic [2:0] RegViewerY = 3'd1;
  localparam logic [2:0] RegFacingX = 3'd2;
  localparam logic [2:0] RegFacingY = 3'd3;
  localparam logic [2:0] RegPlaneX  = 3'd4;
  localparam logic [2:0] RegPlaneY  = 3'd5;
  localparam logic [2:0] RegScreenW = 3'd6;
  localparam logic [2:0] RegScreenH = 3'd7;

  localparam logic signed [CoordW-1:0] ViewerXRst = 32'sd0;
  localparam logic signed [CoordW-1:0] ViewerYRst = 32'sd0;
  localparam logic signed [CoordW-1:0] FacingXRst = 32'sd65536;
  localparam logic signed [CoordW-1:0] FacingYRst = 32'sd0;
  localparam logic signed [CoordW-1:0] PlaneXRst  = 32'sd0;
  localparam logic signed [CoordW-1:0] PlaneYRst  = 32'sd43254;
  localparam logic [DimW-1:0]          ScreenWRst = 13'd640;
  localparam logic [DimW-1:0]          ScreenHRst = 13'd480;

endpackage

`default_nettype wire

[rtl/ssp_in_if.sv]
// ----------------------------------------------------------------------------
// ssp_in_if
// Valid/ready channel carrying one sprite world position per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssp_in_if
  import ssp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] sprite_x;
  logic signed [CoordW-1:0] sprite_y;

  modport source (output valid, output sprite_x, output sprite_y, input ready);
  modport sink   (input valid, input sprite_x, input sprite_y, output ready);
endinterface

`default_nettype wire

[rtl/ssp_out_if.sv]
// ----------------------------------------------------------------------------
// ssp_out_if
// Valid/ready channel carrying one projected sprite result per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssp_out_if
  import ssp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] cam_lateral;
  logic signed [CoordW-1:0] cam_depth;
  logic signed [15:0]       center_column;
  logic [15:0]              sprite_size;
  logic [ScreenBits-1:0]    first_column;
  logic [ScreenBits-1:0]    last_column;
  logic [ScreenBits-1:0]    first_row;
  logic [ScreenBits-1:0]    last_row;
  logic                     depth_zero;

  modport source (
    output valid, output cam_lateral, output cam_depth, output center_column,
    output sprite_size, output first_column, output last_column,
    output first_row, output last_row, output depth_zero, input ready
  );
  modport sink (
    input valid, input cam_lateral, input cam_depth, input center_column,
    input sprite_size, input first_column, input last_column,
    input first_row, input last_row, input depth_zero, output ready
  );
endinterface

`default_nettype wire

[rtl/sprite_screen_projection.sv]
// ----------------------------------------------------------------------------
// sprite_screen_projection
// Throughput: one word per cycle; sixty register stages, most of them in
// the two restoring dividers (32 and 16 one-bit steps), which take a stage
// a bit. The whole pipeline holds while the output word waits to be taken.
// Reset: asynchronous, clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_screen_projection
  import ssp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  ssp_in_if.sink              in_i,
  ssp_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned DivABits  = 32;
  localparam int unsigned DivBBits  = 16;
  localparam int unsigned SizeNumW  = DimW + CoordFracBits;
  localparam int unsigned NumStages = 4 + (DivABits + 1) + 4 + (DivBBits + 1) + 2;

  typedef struct packed {
    logic signed [31:0] lat;
    logic signed [31:0] dep;
    logic               dz;
  } cam_t;

  typedef struct packed {
    logic [63:0] rem_l;
    logic [31:0] low_l;
    logic        ovf_l;
    logic        neg_l;
    logic [63:0] rem_d;
    logic [31:0] low_d;
    logic        ovf_d;
    logic        neg_d;
  } div_a_t;

  typedef struct packed {
    logic [31:0] rem_c;
    logic [15:0] low_c;
    logic        ovf_c;
    logic        neg_c;
    logic [31:0] rem_s;
    logic [15:0] low_s;
    logic        ovf_s;
    logic [31:0] dep_mag;
    cam_t        cam;
  } div_b_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] viewer_x_q, viewer_y_q, facing_x_q, facing_y_q;
  logic signed [31:0] plane_x_q, plane_y_q;
  logic [DimW-1:0]    screen_width_q, screen_height_q;
  logic [2:0]         cfg_idx;
  logic               cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CfgAddrW-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      viewer_x_q      <= ViewerXRst;
      viewer_y_q      <= ViewerYRst;
      facing_x_q      <= FacingXRst;
      facing_y_q      <= FacingYRst;
      plane_x_q       <= PlaneXRst;
      plane_y_q       <= PlaneYRst;
      screen_width_q  <= ScreenWRst;
      screen_height_q <= ScreenHRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegViewerX: viewer_x_q      <= $signed(pwdata);
        RegViewerY: viewer_y_q      <= $signed(pwdata);
        RegFacingX: facing_x_q      <= $signed(pwdata);
        RegFacingY: facing_y_q      <= $signed(pwdata);
        RegPlaneX:  plane_x_q       <= $signed(pwdata);
        RegPlaneY:  plane_y_q       <= $signed(pwdata);
        RegScreenW: screen_width_q  <= pwdata[DimW-1:0];
        RegScreenH: screen_height_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegViewerX: prdata = viewer_x_q;
      RegViewerY: prdata = viewer_y_q;
      RegFacingX: prdata = facing_x_q;
      RegFacingY: prdata = facing_y_q;
      RegPlaneX:  prdata = plane_x_q;
      RegPlaneY:  prdata = plane_y_q;
      RegScreenW: prdata = CfgDataW'(screen_width_q);
      RegScreenH: prdata = CfgDataW'(screen_height_q);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Determinant of the camera matrix. It depends on configuration alone, which the user
  // must keep stable while words are in flight (unenforced), so it runs free of the pipeline.
  // --------------------------------------------------------------------------
  logic signed [63:0] det_p1_q, det_p2_q;
  logic signed [64:0] det_q;
  logic [63:0]        det_mag_q;
  logic               det_neg_q, det_zero_q;

  always_ff @(posedge clk_i) begin
    det_p1_q   <= 64'(plane_x_q) * 64'(facing_y_q);
    det_p2_q   <= 64'(plane_y_q) * 64'(facing_x_q);
    det_q      <= 65'(det_p1_q) - 65'(det_p2_q);
    det_mag_q  <= 64'(det_q[64] ? -det_q : det_q);
    det_neg_q  <= det_q[64];
    det_zero_q <= (det_q == '0);
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage moves together unless the output word waits.
  // --------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;
  logic                 en;

  assign en          = !vld_q[NumStages-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_i.valid};
    end
  end

  // --------------------------------------------------------------------------
  // Helper functions
  // --------------------------------------------------------------------------
  function automatic div_a_t step_a(div_a_t s, logic [63:0] d);
    div_a_t      r;
    logic [64:0] tl, td;
    logic        gl, gd;
    r  = s;
    tl = {s.rem_l, s.low_l[31]};
    td = {s.rem_d, s.low_d[31]};
    gl = (tl >= {1'b0, d});
    gd = (td >= {1'b0, d});
    r.rem_l = gl ? 64'(tl - {1'b0, d}) : tl[63:0];
    r.rem_d = gd ? 64'(td - {1'b0, d}) : td[63:0];
    r.low_l = {s.low_l[30:0], gl};
    r.low_d = {s.low_d[30:0], gd};
    return r;
  endfunction

  function automatic div_b_t step_b(div_b_t s);
    div_b_t      r;
    logic [32:0] tc, ts;
    logic        gc, gs;
    r  = s;
    tc = {s.rem_c, s.low_c[15]};
    ts = {s.rem_s, s.low_s[15]};
    gc = (tc >= {1'b0, s.dep_mag});
    gs = (ts >= {1'b0, s.dep_mag});
    r.rem_c = gc ? 32'(tc - {1'b0, s.dep_mag}) : tc[31:0];
    r.rem_s = gs ? 32'(ts - {1'b0, s.dep_mag}) : ts[31:0];
    r.low_c = {s.low_c[14:0], gc};
    r.low_s = {s.low_s[14:0], gs};
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(logic [31:0] q, logic neg, logic ovf);
    logic [31:0] cap, m;
    cap = {neg, {31{~neg}}};
    m   = (ovf || q > cap) ? cap : q;
    return neg ? $signed(-m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(logic [15:0] q, logic neg, logic ovf);
    logic [15:0] cap, m;
    cap = {neg, {15{~neg}}};
    m   = (ovf || q > cap) ? cap : q;
    return neg ? $signed(-m) : $signed(m);
  endfunction

  // Clamp a bound to 0 .. min(dim, 2^ScreenBits) - 1.
  function automatic logic [ScreenBits-1:0] clip(logic signed [17:0] v, logic [DimW-1:0] dim);
    logic [15:0] lim;
    lim = (16'(dim) < 16'(1 << ScreenBits)) ? 16'(dim) : 16'(1 << ScreenBits);
    lim = (lim != '0) ? 16'(lim - 16'd1) : '0;
    if (v < 0) begin
      return '0;
    end else if (v > $signed(18'(lim))) begin
      return lim[ScreenBits-1:0];
    end else begin
      return v[ScreenBits-1:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic signed [32:0] rx_q, ry_q;
  logic signed [64:0] p_fy_rx_q, p_fx_ry_q, p_px_ry_q, p_py_rx_q;
  logic signed [65:0] nl_q, nd_q;
  logic [63:0]        nl_mag_q, nd_mag_q;
  logic               nl_neg_q, nd_neg_q;
  div_a_t             a_q [DivABits+1];
  div_a_t             a_d [DivABits+1];
  cam_t               cam_d, c1_q, c2_q, c3_q, c4_q;
  logic signed [32:0] sum_q;
  logic [31:0]        dm2_q, dm3_q, dm4_q;
  logic               dn2_q, dn3_q;
  logic signed [45:0] prod_q;
  logic [44:0]        cc_mag_q;
  logic               cc_neg_q;
  div_b_t             b_q [DivBBits+1];
  div_b_t             b_d [DivBBits+1];
  cam_t               c5_q;
  logic signed [15:0] cc_q;
  logic [15:0]        size_q;

  logic [63:0]          top_l, top_d;
  logic signed [31:0]   lat_v, dep_v;
  logic [44:0]          top_c;
  logic [SizeNumW-1:0]  num_s, top_s;

  always_comb begin
    top_l = nl_mag_q >> (32 - CoordFracBits);
    top_d = nd_mag_q >> (32 - CoordFracBits);
    a_d[0].rem_l = top_l;
    a_d[0].low_l = 32'(nl_mag_q << CoordFracBits);
    a_d[0].ovf_l = (top_l >= det_mag_q);
    a_d[0].neg_l = nl_neg_q ^ det_neg_q;
    a_d[0].rem_d = top_d;
    a_d[0].low_d = 32'(nd_mag_q << CoordFracBits);
    a_d[0].ovf_d = (top_d >= det_mag_q);
    a_d[0].neg_d = nd_neg_q ^ det_neg_q;
    for (int k = 0; k < DivABits; k++) begin
      a_d[k+1] = step_a(a_q[k], det_mag_q);
    end

    lat_v     = sat32(a_q[DivABits].low_l, a_q[DivABits].neg_l, a_q[DivABits].ovf_l);
    dep_v     = sat32(a_q[DivABits].low_d, a_q[DivABits].neg_d, a_q[DivABits].ovf_d);
    cam_d.lat = det_zero_q ? '0 : lat_v;
    cam_d.dep = det_zero_q ? '0 : dep_v;
    cam_d.dz  = det_zero_q || (dep_v == '0);

    top_c = cc_mag_q >> 16;
    num_s = SizeNumW'(screen_height_q) << CoordFracBits;
    top_s = num_s >> 16;
    b_d[0].rem_c   = 32'(top_c);
    b_d[0].low_c   = cc_mag_q[15:0];
    b_d[0].ovf_c   = (top_c >= 45'(dm4_q));
    b_d[0].neg_c   = cc_neg_q;
    b_d[0].rem_s   = 32'(top_s);
    b_d[0].low_s   = num_s[15:0];
    b_d[0].ovf_s   = (64'(top_s) >= 64'(dm4_q));
    b_d[0].dep_mag = dm4_q;
    b_d[0].cam     = c4_q;
    for (int k = 0; k < DivBBits; k++) begin
      b_d[k+1] = step_b(b_q[k]);
    end
  end

  logic [14:0]        half;
  logic [11:0]        cy;
  logic signed [17:0] col_lo, col_hi, row_lo, row_hi;

  always_comb begin
    half   = size_q[15:1];
    cy     = screen_height_q[DimW-1:1];
    col_lo = 18'(cc_q) - $signed({3'b000, half});
    col_hi = 18'(cc_q) + $signed({3'b000, half});
    row_lo = $signed({6'b0, cy}) - $signed({3'b000, half});
    row_hi = $signed({6'b0, cy}) + $signed({3'b000, half});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Offsets from the viewer.
      rx_q <= 33'(in_i.sprite_x) - 33'(viewer_x_q);
      ry_q <= 33'(in_i.sprite_y) - 33'(viewer_y_q);
      // Products of the inverse camera matrix, scaled by the determinant.
      p_fy_rx_q <= 65'(facing_y_q) * 65'(rx_q);
      p_fx_ry_q <= 65'(facing_x_q) * 65'(ry_q);
      p_px_ry_q <= 65'(plane_x_q) * 65'(ry_q);
      p_py_rx_q <= 65'(plane_y_q) * 65'(rx_q);
      nl_q <= 66'(p_fy_rx_q) - 66'(p_fx_ry_q);
      nd_q <= 66'(p_px_ry_q) - 66'(p_py_rx_q);
      nl_mag_q <= 64'(nl_q[65] ? -nl_q : nl_q);
      nd_mag_q <= 64'(nd_q[65] ? -nd_q : nd_q);
      nl_neg_q <= nl_q[65];
      nd_neg_q <= nd_q[65];
      a_q <= a_d;
      c1_q  <= cam_d;
      c2_q  <= c1_q;
      sum_q <= 33'(c1_q.dep) + 33'(c1_q.lat);
      dm2_q <= c1_q.dep[31] ? 32'(-c1_q.dep) : 32'(c1_q.dep);
      dn2_q <= c1_q.dep[31];
      c3_q   <= c2_q;
      prod_q <= 46'($signed({1'b0, screen_width_q[DimW-1:1]})) * 46'(sum_q);
      dm3_q  <= dm2_q;
      dn3_q  <= dn2_q;
      c4_q     <= c3_q;
      cc_mag_q <= 45'(prod_q[45] ? -prod_q : prod_q);
      cc_neg_q <= prod_q[45] ^ dn3_q;
      dm4_q    <= dm3_q;
      b_q <= b_d;
      c5_q   <= b_q[DivBBits].cam;
      cc_q   <= sat16(b_q[DivBBits].low_c, b_q[DivBBits].neg_c, b_q[DivBBits].ovf_c);
      size_q <= b_q[DivBBits].ovf_s ? 16'hFFFF : b_q[DivBBits].low_s;
      // Output word.
      out_o.cam_lateral   <= c5_q.lat;
      out_o.depth_zero    <= c5_q.dz;
      out_o.cam_depth     <= c5_q.dz ? '0 : c5_q.dep;
      out_o.center_column <= c5_q.dz ? '0 : cc_q;
      out_o.sprite_size   <= c5_q.dz ? '0 : size_q;
      out_o.first_column  <= c5_q.dz ? '0 : clip(col_lo, screen_width_q);
      out_o.last_column   <= c5_q.dz ? '0 : clip(col_hi, screen_width_q);
      out_o.first_row     <= c5_q.dz ? '0 : clip(row_lo, screen_height_q);
      out_o.last_row      <= c5_q.dz ? '0 : clip(row_hi, screen_height_q);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_zero_depth_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.depth_zero |->
      out_o.cam_depth == '0 && out_o.sprite_size == '0 && out_o.center_column == '0)
    else $error("zero depth word carries nonzero projection");

  a_ranges_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.depth_zero |->
      out_o.first_row <= out_o.last_row && out_o.first_column <= out_o.last_column)
    else $error("clipped range out of order");

  a_column_in_screen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && screen_width_q != '0 |->
      DimW'(out_o.last_column) < screen_width_q)
    else $error("last column beyond screen width");

endmodule

`default_nettype wire

[tb/sv/sprite_screen_projection_tb.sv]
// ----------------------------------------------------------------------------
// sprite_screen_projection_tb
// Self-checking bench for the sprite projection pipeline. Sprite positions are
// pushed through the input channel under several camera and screen settings.
// A scoreboard computes the camera-space position, the screen column, the size
// and the clipped ranges of every accepted word. It compares them with each
// output word in order. Both channel sides idle at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_screen_projection_tb;
  import ssp_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [31:0] lat;
    logic [31:0] dep;
    logic [15:0] cc;
    logic [15:0] size;
    logic [11:0] fc;
    logic [11:0] lc;
    logic [11:0] fr;
    logic [11:0] lr;
    logic        dz;
  } proj_t;

  class projection_scoreboard;
    longint vx, vy, fx, fy, px, py;
    longint sw, sh;
    proj_t  pending[$];
    int     errors;

    function new();
      vx = 0; vy = 0; fx = 65536; fy = 0; px = 0; py = 43254;
      sw = 640; sh = 480;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        RegViewerX: vx = longint'($signed(v));
        RegViewerY: vy = longint'($signed(v));
        RegFacingX: fx = longint'($signed(v));
        RegFacingY: fy = longint'($signed(v));
        RegPlaneX:  px = longint'($signed(v));
        RegPlaneY:  py = longint'($signed(v));
        RegScreenW: sw = longint'(v[12:0]);
        default:    sh = longint'(v[12:0]);
      endcase
    endfunction

    function wide_t sat(wide_t v, wide_t lo, wide_t hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function logic [11:0] clip(wide_t v, longint dim);
      wide_t lim;
      lim = (dim < 4096) ? dim : 4096;
      lim = (lim > 0) ? lim - 1 : 0;
      return 12'(sat(v, 0, lim));
    endfunction

    // Predicts the result word for one accepted sprite position.
    function void note(logic [31:0] sx, logic [31:0] sy);
      wide_t rx, ry, det, nl, nd, lat, dep, cc, size, half, cy, w_fx, w_fy, w_px, w_py;
      proj_t e;
      e = '{default: '0};
      rx = wide_t'(longint'($signed(sx)) - vx);
      ry = wide_t'(longint'($signed(sy)) - vy);
      w_fx = fx; w_fy = fy; w_px = px; w_py = py;
      det = w_px * w_fy - w_py * w_fx;
      nl = w_fy * rx - w_fx * ry;
      nd = w_px * ry - w_py * rx;
      if (det == 0) begin
        e.dz = 1'b1;
      end else begin
        lat = sat((nl * 65536) / det, -64'sd2147483648, 64'sd2147483647);
        dep = sat((nd * 65536) / det, -64'sd2147483648, 64'sd2147483647);
        e.lat = 32'(lat);
        if (dep == 0) begin
          e.dz = 1'b1;
        end else begin
          e.dep = 32'(dep);
          cc = sat((wide_t'(sw / 2) * (dep + lat)) / dep, -32768, 32767);
          size = sat((wide_t'(sh) * 65536) / ((dep < 0) ? -dep : dep), 0, 65535);
          half = size / 2;
          cy = sh / 2;
          e.cc = 16'(cc);
          e.size = 16'(size);
          e.fc = clip(cc - half, sw);
          e.lc = clip(cc + half, sw);
          e.fr = clip(cy - half, sh);
          e.lr = clip(cy + half, sh);
        end
      end
      pending.push_back(e);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check(proj_t a);
      proj_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output word, lateral %h depth %h", $time, a.lat, a.dep);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("cam_lateral", e.lat, a.lat);
      cmp("cam_depth", e.dep, a.dep);
      cmp("center_column", 32'(e.cc), 32'(a.cc));
      cmp("sprite_size", 32'(e.size), 32'(a.size));
      cmp("first_column", 32'(e.fc), 32'(a.fc));
      cmp("last_column", 32'(e.lc), 32'(a.lc));
      cmp("first_row", 32'(e.fr), 32'(a.fr));
      cmp("last_row", 32'(e.lr), 32'(a.lr));
      cmp("depth_zero", 32'(e.dz), 32'(a.dz));
    endfunction
  endclass

  localparam int unsigned CycleLimit = 600000;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  ssp_in_if  in_bus();
  ssp_out_if out_bus();

  projection_scoreboard sb;
  int unsigned cycles;
  bit hold_req;
  bit quiet;

  sprite_screen_projection u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin : receiver
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_bus.ready = 1'b0;
        repeat (300) @(negedge clk);
        held = 1'b1;
      end else if (stall > 0) begin
        out_bus.ready = 1'b0;
        stall--;
      end else begin
        out_bus.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    proj_t a;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      a.lat = out_bus.cam_lateral;
      a.dep = out_bus.cam_depth;
      a.cc = out_bus.center_column;
      a.size = out_bus.sprite_size;
      a.fc = out_bus.first_column;
      a.lc = out_bus.last_column;
      a.fr = out_bus.first_row;
      a.lr = out_bus.last_row;
      a.dz = out_bus.depth_zero;
      sb.check(a);
    end
  end

  task automatic send_sprite(logic [31:0] x, logic [31:0] y);
    int g;
    g = gap_len();
    repeat (g) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.sprite_x = x;
    in_bus.sprite_y = y;
    do @(posedge clk); while (!in_bus.ready);
    sb.note(x, y);
    @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CfgAddrW'({idx, 2'b00});
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Lets the pipeline empty out before any register changes.
  task automatic drain();
    in_bus.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic write_all(logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) reg_write(3'(i), v[i]);
  endtask

  function automatic logic [31:0] soff(int unsigned range);
    return 32'($signed(int'($urandom_range(0, 2 * range)) - int'(range)));
  endfunction

  initial begin : stimulus
    logic [31:0] cfg[8];
    longint fxr, fyr;
    int mode;
    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_bus.valid = 1'b0; in_bus.sprite_x = '0; in_bus.sprite_y = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset defaults: ahead, at the viewer, behind, tiny depth, extremes.
    send_sprite(32'sd327680, 32'sd0);
    send_sprite(32'sd0, 32'sd0);
    send_sprite(-32'sd327680, 32'sd65536);
    send_sprite(32'sd1, 32'sd0);
    send_sprite(32'sd196608, 32'sd6553600);
    send_sprite(32'h7fffffff, 32'h7fffffff);
    send_sprite(32'h80000000, 32'h80000000);
    send_sprite(32'h7fffffff, 32'h80000000);
    send_sprite(32'h80000000, 32'h7fffffff);
    send_sprite(32'hffffffff, 32'h00000000);
    drain();
    // Singular camera matrix.
    cfg = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd43254, 32'd640, 32'd480};
    write_all(cfg);
    send_sprite(32'sd327680, 32'sd65536);
    send_sprite(32'h80000000, 32'h7fffffff);
    drain();
    // Extreme registers and dimensions.
    cfg = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h7fffffff, 32'h80000000, 32'h1fff, 32'h0};
    write_all(cfg);
    send_sprite(32'h7fffffff, 32'h80000000);
    send_sprite(32'h0, 32'h0);
    send_sprite(32'h12345678, 32'h9abcdef0);
    drain();
    cfg = '{32'h7fffffff, 32'h80000000, 32'h1, 32'h0, 32'h0, 32'h1, 32'd1, 32'd4096};
    write_all(cfg);
    send_sprite(32'h80000000, 32'h7fffffff);
    send_sprite(32'h7fffffff, 32'h80000001);
    send_sprite(32'h7ffffffe, 32'h80000000);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      mode = ph % 3;
      quiet = (ph == 4);
      fxr = longint'($signed(soff(131072)));
      fyr = longint'($signed(soff(131072)));
      if (mode == 2) begin
        for (int i = 0; i < 6; i++) cfg[i] = $urandom();
      end else begin
        cfg[0] = soff(1 << 24);
        cfg[1] = soff(1 << 24);
        cfg[2] = 32'(fxr);
        cfg[3] = 32'(fyr);
        cfg[4] = 32'(-(fyr * 43254) / 65536 + longint'($signed(soff(500))));
        cfg[5] = 32'((fxr * 43254) / 65536 + longint'($signed(soff(500))));
      end
      cfg[6] = (ph == 7) ? 32'h1fff : ((ph == 8) ? 32'd0 : $urandom_range(1, 4096));
      cfg[7] = (ph == 7) ? 32'd0 : ((ph == 8) ? 32'h1fff : $urandom_range(1, 4096));
      if (ph == 9) begin
        cfg[6] = 32'(~$urandom_range(0, 8191));
        cfg[7] = 32'($urandom());
      end
      write_all(cfg);
      for (int k = 0; k < 85; k++) begin
        if (ph == 3 && k == 10) hold_req = 1'b1;
        if (mode == 2 || $urandom_range(0, 4) == 0)
          send_sprite($urandom(), $urandom());
        else
          send_sprite(cfg[0] + soff(1 << 22), cfg[1] + soff(1 << 22));
      end
      drain();
    end

    in_bus.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/ssp_pkg.sv
rtl/ssp_in_if.sv
rtl/ssp_out_if.sv
rtl/sprite_screen_projection.sv
tb/sv/sprite_screen_projection_tb.sv
